/* hdl/gyro_bias_noise_drift_calibrator_macros.svh */
// Assertion macros for the gyro bias, noise and drift calibrator.
// Included by the top level; depends on nothing else.
`ifndef GYRO_BIAS_NOISE_DRIFT_CALIBRATOR_MACROS_SVH
`define GYRO_BIAS_NOISE_DRIFT_CALIBRATOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/gbc_pkg.sv */
// Shared types, codes and constants of the gyro bias, noise and drift calibrator.
// Used by the channel interfaces, the arithmetic unit and the top level.
package gbc_pkg;

    localparam int MAX_SAMPLES_DEF = 1024;
    localparam int MS_TO_US        = 1000;
    localparam int AR_W            = 64;
    localparam int PADDR_W         = 4;
    localparam logic [22:0] DRIFT_MAX = 23'h7FFFFF;

    localparam logic [15:0] STABLE_WAIT_RST = 16'd1000;
    localparam logic [15:0] PERIOD_RST      = 16'd30000;
    localparam logic [10:0] LIMIT_RST       = 11'd1000;

    localparam logic [1:0] REG_STABLE_WAIT = 2'd0;
    localparam logic [1:0] REG_PERIOD      = 2'd1;
    localparam logic [1:0] REG_LIMIT       = 2'd2;
    localparam logic [1:0] REG_BYPASS      = 2'd3;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_FAIL   = 2'd1,
        OP_REDO   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PH_WAIT_STREAM = 3'd0,
        PH_FAILED      = 3'd1,
        PH_WAIT_STABLE = 3'd2,
        PH_MEASURE     = 3'd3,
        PH_COMPLETE    = 3'd4,
        PH_TEST        = 3'd5
    } t_phase;

    typedef enum logic [4:0] {
        S_IDLE, S_CTRL, S_DRIFT, S_RD, S_ACC,
        S_BIAS_GO, S_BIAS_WAIT, S_N2_GO, S_N2_WAIT, S_SQ_GO, S_SQ_WAIT,
        S_NN_GO, S_NN_WAIT, S_VAR_GO, S_VAR_WAIT, S_DR_GO, S_DR_WAIT,
        S_NEXT_AX, S_EMIT
    } t_state;

    typedef enum logic {
        AOP_MUL = 1'b0,
        AOP_DIV = 1'b1
    } t_aop;

    typedef struct packed {
        logic              start;
        t_aop              op;
        logic [AR_W-1:0]   a;
        logic [AR_W-1:0]   b;
    } t_arith_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [AR_W-1:0]   result;
    } t_arith_rsp;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [15:0] gyro_x;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_z;
        logic [15:0]        delta_us;
        logic               is_stable;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         phase;
        logic               done_res;
        logic signed [23:0] bias_x;
        logic signed [23:0] bias_y;
        logic signed [23:0] bias_z;
        logic [22:0]        drift_peak;
        logic [37:0]        noise_variance;
    } t_out_item;

endpackage

/* hdl/gbc_if.sv */
// Valid/ready channel interfaces for input and result items.
// Depends on gbc_pkg for the payload types.
interface gbc_in_if;
    import gbc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface gbc_out_if;
    import gbc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* hdl/gyro_bias_noise_drift_calibrator.sv */
// Gyro bias, noise and drift calibrator: one result item per input item.
// Plain items pass the control and emit steps, measuring samples also a drift step per
// axis; the completing item scans the sample memory per axis and runs up to 6 serial
// operations per axis on the shared unit.
// One item is in work at a time. Synchronous active-low reset restores register
// defaults and clears phase, counters and results; the sample memory is not cleared.
`include "gyro_bias_noise_drift_calibrator_macros.svh"

module gyro_bias_noise_drift_calibrator #(
    parameter int MAX_SAMPLES = gbc_pkg::MAX_SAMPLES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    gbc_in_if.sink                     i_in,
    gbc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [gbc_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import gbc_pkg::*;

    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int AW   = $clog2(MAX_SAMPLES);
    localparam int SUMW = 17 + CW;
    localparam int S1W  = 16 + CW;
    localparam int S2W  = 32 + CW;

    logic [15:0]            r_stable_wait;
    logic [15:0]            r_period;
    logic [10:0]            r_limit;
    logic                   r_bypass;

    t_state                 r_state, n_state;
    t_phase                 r_phase;
    logic                   r_stable_seen;
    logic [31:0]            r_stable_us;
    logic [31:0]            r_meas_us;
    logic [CW-1:0]          r_count;
    logic signed [47:0]     r_drift [3];
    logic [23:0]            r_bias [3];
    logic [22:0]            r_hold_drift;
    logic [AR_W-1:0]        r_hold_var;
    logic                   r_done;
    logic                   r_finish;
    t_in_item               r_item;
    logic [1:0]             r_ax;
    logic [CW-1:0]          r_idx;
    logic signed [SUMW-1:0] r_sum;
    logic [S1W-1:0]         r_s1;
    logic [S2W-1:0]         r_s2;
    logic [AR_W-1:0]        r_p1;
    logic [AR_W-1:0]        r_p2;
    logic [AR_W-1:0]        r_p3;
    logic [47:0]            r_mem_q;
    logic [47:0]            mem [MAX_SAMPLES];
    t_out_item              r_out;
    logic                   r_out_valid;

    t_arith_req             arith_req;
    t_arith_rsp             arith_rsp;

    t_op                    op;
    logic [32:0]            stable_add;
    logic [32:0]            meas_add;
    logic [31:0]            stable_sat;
    logic [31:0]            meas_sat;
    logic [31:0]            wait_thr;
    logic [31:0]            per_thr;
    logic                   lim_ok;
    logic                   mem_we;
    logic                   meas_step;
    logic signed [15:0]     g_in;
    logic signed [15:0]     g_mem;
    logic [15:0]            a_mem;
    logic signed [32:0]     drift_prod;
    logic [SUMW-1:0]        sum_abs;
    logic [47:0]            drift_abs;
    logic [22:0]            drift_q;

    gbc_arith u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (arith_req),
        .o_rsp   (arith_rsp)
    );

    assign op         = t_op'(r_item.operation);
    assign stable_add = {1'b0, r_stable_us} + 33'(r_item.delta_us);
    assign meas_add   = {1'b0, r_meas_us} + 33'(r_item.delta_us);
    assign stable_sat = stable_add[32] ? 32'hFFFF_FFFF : stable_add[31:0];
    assign meas_sat   = meas_add[32] ? 32'hFFFF_FFFF : meas_add[31:0];
    assign wait_thr   = 32'(r_stable_wait) * 32'(MS_TO_US);
    assign per_thr    = 32'(r_period) * 32'(MS_TO_US);
    assign lim_ok     = (32'(r_count) < 32'(r_limit)) && (32'(r_count) < 32'(MAX_SAMPLES));
    assign meas_step  = (op == OP_SAMPLE) && (r_phase == PH_MEASURE) && r_item.is_stable;
    assign mem_we     = (r_state == S_CTRL) && meas_step && lim_ok;

    always_comb begin
        unique case (r_ax)
            2'd0:    g_in = r_item.gyro_x;
            2'd1:    g_in = r_item.gyro_y;
            default: g_in = r_item.gyro_z;
        endcase
        unique case (r_ax)
            2'd0:    g_mem = r_mem_q[15:0];
            2'd1:    g_mem = r_mem_q[31:16];
            default: g_mem = r_mem_q[47:32];
        endcase
    end

    assign a_mem      = g_mem[15] ? (~g_mem + 16'd1) : g_mem;
    assign drift_prod = g_in * $signed({1'b0, r_item.delta_us});
    assign sum_abs    = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign drift_abs  = r_drift[r_ax][47] ? 48'(-r_drift[r_ax]) : 48'(r_drift[r_ax]);
    assign drift_q    = (arith_rsp.result > AR_W'(DRIFT_MAX)) ? DRIFT_MAX
                                                              : arith_rsp.result[22:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:      if (i_in.valid) n_state = S_CTRL;
            S_CTRL:      n_state = meas_step ? S_DRIFT : S_EMIT;
            S_DRIFT:     if (r_ax == 2'd2) n_state = r_finish ? S_RD : S_EMIT;
            S_RD:        n_state = (r_idx == r_count) ? S_BIAS_GO : S_ACC;
            S_ACC:       n_state = S_RD;
            S_BIAS_GO:   n_state = (r_count == '0) ? S_N2_GO : S_BIAS_WAIT;
            S_BIAS_WAIT: if (arith_rsp.done) n_state = S_N2_GO;
            S_N2_GO:     n_state = (32'(r_count) < 32'd2) ? S_DR_GO : S_N2_WAIT;
            S_N2_WAIT:   if (arith_rsp.done) n_state = S_SQ_GO;
            S_SQ_GO:     n_state = S_SQ_WAIT;
            S_SQ_WAIT:   if (arith_rsp.done) n_state = S_NN_GO;
            S_NN_GO:     n_state = S_NN_WAIT;
            S_NN_WAIT:   if (arith_rsp.done) n_state = S_VAR_GO;
            S_VAR_GO:    n_state = S_VAR_WAIT;
            S_VAR_WAIT:  if (arith_rsp.done) n_state = S_DR_GO;
            S_DR_GO:     n_state = (r_meas_us == '0) ? S_NEXT_AX : S_DR_WAIT;
            S_DR_WAIT:   if (arith_rsp.done) n_state = S_NEXT_AX;
            S_NEXT_AX:   n_state = (r_ax == 2'd2) ? S_EMIT : S_RD;
            S_EMIT:      if (!r_out_valid || o_out.ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // Requests to the shared unit.
    always_comb begin
        arith_req = '0;
        unique case (r_state)
            S_BIAS_GO: begin
                arith_req.start = (r_count != '0);
                arith_req.op    = AOP_DIV;
                arith_req.a     = AR_W'(sum_abs) << 8;
                arith_req.b     = AR_W'(r_count);
            end
            S_N2_GO: begin
                arith_req.start = (32'(r_count) >= 32'd2);
                arith_req.op    = AOP_MUL;
                arith_req.a     = AR_W'(r_count);
                arith_req.b     = AR_W'(r_s2);
            end
            S_SQ_GO: begin
                arith_req.start = 1'b1;
                arith_req.op    = AOP_MUL;
                arith_req.a     = AR_W'(r_s1);
                arith_req.b     = AR_W'(r_s1);
            end
            S_NN_GO: begin
                arith_req.start = 1'b1;
                arith_req.op    = AOP_MUL;
                arith_req.a     = AR_W'(r_count);
                arith_req.b     = AR_W'(r_count - 1'b1);
            end
            S_VAR_GO: begin
                arith_req.start = 1'b1;
                arith_req.op    = AOP_DIV;
                arith_req.a     = (r_p1 - r_p2) << 8;
                arith_req.b     = r_p3;
            end
            S_DR_GO: begin
                arith_req.start = (r_meas_us != '0);
                arith_req.op    = AOP_DIV;
                arith_req.a     = AR_W'(drift_abs) << 8;
                arith_req.b     = AR_W'(r_meas_us);
            end
            default: arith_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_phase       <= PH_WAIT_STREAM;
            r_stable_seen <= 1'b0;
            r_stable_us   <= '0;
            r_meas_us     <= '0;
            r_count       <= '0;
            r_drift       <= '{default: '0};
            r_bias        <= '{default: '0};
            r_hold_drift  <= '0;
            r_hold_var    <= '0;
            r_done        <= 1'b0;
            r_finish      <= 1'b0;
            r_ax          <= '0;
            r_idx         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && o_out.ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CTRL: begin
                    r_done   <= 1'b0;
                    r_finish <= 1'b0;
                    r_ax     <= '0;
                    unique case (op)
                        OP_FAIL: r_phase <= PH_FAILED;
                        OP_REDO: begin
                            if (r_phase == PH_COMPLETE) begin
                                r_count      <= '0;
                                r_drift      <= '{default: '0};
                                r_bias       <= '{default: '0};
                                r_hold_drift <= '0;
                                r_hold_var   <= '0;
                                r_phase      <= PH_WAIT_STABLE;
                            end
                        end
                        OP_SAMPLE: begin
                            unique case (r_phase)
                                PH_WAIT_STREAM: begin
                                    r_phase <= r_bypass ? PH_TEST : PH_WAIT_STABLE;
                                end
                                PH_WAIT_STABLE: begin
                                    if (!r_item.is_stable) begin
                                        r_stable_seen <= 1'b0;
                                    end else if (!r_stable_seen) begin
                                        r_stable_seen <= 1'b1;
                                        r_stable_us   <= '0;
                                    end else begin
                                        r_stable_us <= stable_sat;
                                        if (stable_sat >= wait_thr) begin
                                            r_count      <= '0;
                                            r_drift      <= '{default: '0};
                                            r_bias       <= '{default: '0};
                                            r_hold_drift <= '0;
                                            r_hold_var   <= '0;
                                            r_meas_us    <= '0;
                                            r_phase      <= PH_MEASURE;
                                        end
                                    end
                                end
                                PH_MEASURE: begin
                                    if (r_item.is_stable) begin
                                        r_meas_us <= meas_sat;
                                        if (lim_ok) begin
                                            r_count <= r_count + 1'b1;
                                        end
                                        if (meas_sat >= per_thr) begin
                                            r_finish     <= 1'b1;
                                            r_done       <= 1'b1;
                                            r_hold_drift <= '0;
                                            r_hold_var   <= '0;
                                            r_phase      <= PH_COMPLETE;
                                        end
                                    end else begin
                                        r_stable_seen <= 1'b0;
                                        r_phase       <= PH_WAIT_STABLE;
                                    end
                                end
                                default: r_phase <= r_phase;
                            endcase
                        end
                        default: r_phase <= r_phase;
                    endcase
                end
                S_DRIFT: begin
                    r_drift[r_ax] <= r_drift[r_ax] + 48'(drift_prod);
                    if (r_ax == 2'd2) begin
                        r_ax  <= '0;
                        r_idx <= '0;
                    end else begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_ACC: r_idx <= r_idx + 1'b1;
                S_BIAS_GO: begin
                    if (r_count == '0) begin
                        r_bias[r_ax] <= '0;
                    end
                end
                S_BIAS_WAIT: begin
                    if (arith_rsp.done) begin
                        r_bias[r_ax] <= r_sum[SUMW-1] ? (24'd0 - arith_rsp.result[23:0])
                                                      : arith_rsp.result[23:0];
                    end
                end
                S_VAR_WAIT: begin
                    if (arith_rsp.done && (arith_rsp.result > r_hold_var)) begin
                        r_hold_var <= arith_rsp.result;
                    end
                end
                S_DR_WAIT: begin
                    if (arith_rsp.done && (drift_q > r_hold_drift)) begin
                        r_hold_drift <= drift_q;
                    end
                end
                S_NEXT_AX: begin
                    r_idx <= '0;
                    if (r_ax != 2'd2) begin
                        r_ax <= r_ax + 2'd1;
                    end
                end
                S_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: r_idx <= r_idx;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_item <= i_in.data;
        end
        if (r_state == S_DRIFT || r_state == S_NEXT_AX) begin
            r_sum <= '0;
            r_s1  <= '0;
            r_s2  <= '0;
        end else if (r_state == S_ACC) begin
            r_sum <= r_sum + SUMW'(g_mem);
            r_s1  <= r_s1 + S1W'(a_mem);
            r_s2  <= r_s2 + S2W'(a_mem) * S2W'(a_mem);
        end
        if (r_state == S_N2_WAIT && arith_rsp.done) begin
            r_p1 <= arith_rsp.result;
        end
        if (r_state == S_SQ_WAIT && arith_rsp.done) begin
            r_p2 <= arith_rsp.result;
        end
        if (r_state == S_NN_WAIT && arith_rsp.done) begin
            r_p3 <= arith_rsp.result;
        end
        if (r_state == S_EMIT && (!r_out_valid || o_out.ready)) begin
            r_out.phase          <= r_phase;
            r_out.done_res       <= r_done;
            r_out.bias_x         <= r_bias[0];
            r_out.bias_y         <= r_bias[1];
            r_out.bias_z         <= r_bias[2];
            r_out.drift_peak     <= r_hold_drift;
            r_out.noise_variance <= r_hold_var[37:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[AW-1:0]] <= {r_item.gyro_z, r_item.gyro_y, r_item.gyro_x};
        end
        r_mem_q <= mem[r_idx[AW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable_wait <= STABLE_WAIT_RST;
            r_period      <= PERIOD_RST;
            r_limit       <= LIMIT_RST;
            r_bypass      <= 1'b0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_STABLE_WAIT: r_stable_wait <= pwdata[15:0];
                REG_PERIOD:      r_period      <= pwdata[15:0];
                REG_LIMIT:       r_limit       <= pwdata[10:0];
                REG_BYPASS:      r_bypass      <= pwdata[0];
                default:         r_bypass      <= r_bypass;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_STABLE_WAIT: prdata = 32'(r_stable_wait);
            REG_PERIOD:      prdata = 32'(r_period);
            REG_LIMIT:       prdata = 32'(r_limit);
            REG_BYPASS:      prdata = 32'(r_bypass);
            default:         prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    `GBC_ASSERT_NEXT(a_accept_ctrl, i_clk, i_rst_n, i_in.valid && i_in.ready, r_state == S_CTRL, "accepted item did not enter control step")
    `GBC_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, 32'(r_count) <= 32'(MAX_SAMPLES), "sample count exceeds memory depth")
    `GBC_ASSERT_NOW(a_done_phase, i_clk, i_rst_n, r_out_valid && r_out.done_res, r_out.phase == PH_COMPLETE, "done result outside complete phase")

endmodule

/* hdl/gbc_arith.sv */
// Shared bit-serial arithmetic unit: shift-add multiply and restoring divide.
// Both give 64-bit results modulo 2^64; depends on gbc_pkg.
module gbc_arith (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gbc_pkg::t_arith_req i_req,
    output gbc_pkg::t_arith_rsp o_rsp
);
    import gbc_pkg::*;

    localparam int CNT_W = $clog2(AR_W);

    logic             r_busy;
    logic             r_done;
    t_aop             r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [AR_W-1:0]  r_acc;
    logic [AR_W-1:0]  r_x;
    logic [AR_W-1:0]  r_y;
    logic [AR_W:0]    r_rem;

    logic [AR_W:0]    rem_sh;
    logic             fits;

    assign rem_sh = {r_rem[AR_W-1:0], r_x[AR_W-1]};
    assign fits   = rem_sh >= {1'b0, r_y};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(AR_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_op  <= i_req.op;
            r_acc <= '0;
            r_x   <= i_req.a;
            r_y   <= i_req.b;
            r_rem <= '0;
        end else if (r_busy) begin
            r_x <= r_x << 1;
            if (r_op == AOP_MUL) begin
                if (r_y[0]) begin
                    r_acc <= r_acc + (r_x);
                end
                r_y <= r_y >> 1;
            end else begin
                r_acc <= {r_acc[AR_W-2:0], fits};
                r_rem <= fits ? (rem_sh - {1'b0, r_y}) : rem_sh;
            end
        end
    end

    assign o_rsp.busy   = r_busy;
    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule
